FILE: sv/l4hx_pkg.sv
// Shared types, constants and helper functions for the IPv4/L4 header extractor.
// No dependencies; used by l4hx_parser, l4hx_result_queue and the top level.
package l4hx_pkg;

    // Frame byte offsets (Ethernet + fixed 20-byte IPv4 header)
    localparam logic [15:0] POS_ETYPE_HI  = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO  = 16'd13;
    localparam logic [15:0] POS_IP_START  = 16'd14;
    localparam logic [15:0] POS_PROTO     = 16'd23;
    localparam logic [15:0] POS_SRC_FIRST = 16'd26;
    localparam logic [15:0] POS_SRC_LAST  = 16'd29;
    localparam logic [15:0] POS_DST_FIRST = 16'd30;
    localparam logic [15:0] POS_DST_LAST  = 16'd33;
    localparam logic [15:0] L4_OFFSET     = 16'd34;
    localparam logic [15:0] ICMP_ID_SKIP  = 16'd4;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [15:0] TCP_HDR_LEN  = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
    localparam logic [15:0] ICMP_HDR_LEN = 16'd8;

    // Payload capture limit per frame
    localparam logic [7:0] CAPTURE_BYTES = 8'd128;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_RECORD  = 1'b1;

    // Result queue depth: room for two results of one byte plus one waiting
    localparam int QDEPTH = 3;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  protocol_number;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] frame_size;
        logic [7:0]  payload_length;
        logic [63:0] timestamp;
        logic        final_result;
    } result_t;

    // Results produced by one byte: payload first, then record
    typedef struct packed {
        logic    pay_valid;
        logic    rec_valid;
        result_t pay;
        result_t rec;
    } res_pair_t;

    // L4 header length for the protocols handled, 0 for anything else
    function automatic logic [15:0] l4_hdr_len(input logic [7:0] proto);
        logic [15:0] len;
        len = 16'd0;
        if (proto == PROTO_TCP)
            len = TCP_HDR_LEN;
        else if (proto == PROTO_UDP)
            len = UDP_HDR_LEN;
        else if (proto == PROTO_ICMP)
            len = ICMP_HDR_LEN;
        return len;
    endfunction

endpackage

FILE: sv/l4hx_parser.sv
// Per-frame header state and the combinational field/result decode for one byte.
// Depends on l4hx_pkg.
module l4hx_parser
    import l4hx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic [63:0] time_now,
    output res_pair_t   results
);

    logic [15:0] pos_reg,   pos_next;
    logic [15:0] etype_reg, etype_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg,   src_next;
    logic [31:0] dst_reg,   dst_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [7:0]  cap_reg,   cap_next;

    logic        is_ip;
    logic        fits;
    logic [15:0] hlen;
    logic [15:0] start_pos;
    logic [15:0] sp_off;
    logic [15:0] frame_size;

    always_comb
    begin
        etype_next = etype_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        cap_next   = cap_reg;
        results    = '0;

        if (pos_reg == POS_ETYPE_HI)
            etype_next = {data_byte, 8'h00};
        else if (pos_reg == POS_ETYPE_LO)
            etype_next = etype_reg | {8'h00, data_byte};
        else if (pos_reg == POS_PROTO)
            proto_next = data_byte;
        else if (pos_reg >= POS_SRC_FIRST && pos_reg <= POS_SRC_LAST)
            src_next = {src_reg[23:0], data_byte};
        else if (pos_reg >= POS_DST_FIRST && pos_reg <= POS_DST_LAST)
            dst_next = {dst_reg[23:0], data_byte};

        is_ip     = (pos_reg >= POS_IP_START) && (etype_next == ETHERTYPE_IPV4);
        hlen      = l4_hdr_len(proto_next);
        start_pos = L4_OFFSET + hlen;
        sp_off    = (proto_next == PROTO_ICMP) ? (L4_OFFSET + ICMP_ID_SKIP) : L4_OFFSET;

        if (is_ip && hlen != 16'd0)
        begin
            if (pos_reg == sp_off || pos_reg == sp_off + 16'd1)
                sport_next = {sport_reg[7:0], data_byte};
            else if (pos_reg == sp_off + 16'd2 || pos_reg == sp_off + 16'd3)
                dport_next = {dport_reg[7:0], data_byte};

            if (pos_reg >= start_pos && cap_reg < CAPTURE_BYTES)
            begin
                results.pay_valid = 1'b1;
                cap_next          = cap_reg + 8'd1;
            end
        end

        frame_size = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 16'd1;
        fits       = (hlen != 16'd0) && (frame_size >= start_pos);

        results.rec_valid = frame_end && is_ip && (frame_size >= L4_OFFSET);

        results.pay.result_kind  = KIND_PAYLOAD;
        results.pay.payload_byte = data_byte;
        results.pay.final_result = !results.rec_valid;

        results.rec.result_kind     = KIND_RECORD;
        results.rec.source_address  = src_next;
        results.rec.dest_address    = dst_next;
        results.rec.protocol_number = proto_next;
        results.rec.source_port     = fits ? sport_next : 16'd0;
        results.rec.dest_port       = fits ? dport_next : 16'd0;
        results.rec.frame_size      = frame_size;
        results.rec.payload_length  = cap_next;
        results.rec.timestamp       = time_now;
        results.rec.final_result    = 1'b1;

        pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            etype_reg <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            cap_reg   <= '0;
        end
        else if (take)
        begin
            if (frame_end)
            begin
                // frame done: all per-frame state back to zero
                pos_reg   <= '0;
                etype_reg <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
                sport_reg <= '0;
                dport_reg <= '0;
                cap_reg   <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                etype_reg <= etype_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                sport_reg <= sport_next;
                dport_reg <= dport_next;
                cap_reg   <= cap_next;
            end
        end
    end

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && frame_end |=> pos_reg == 16'd0 && cap_reg == 8'd0 && etype_reg == 16'd0)
        else $error("per-frame state not cleared after last byte");

    a_cap_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg <= CAPTURE_BYTES)
        else $error("captured count beyond limit");

    a_payload_needs_ip: assert property (@(posedge clk) disable iff (!rst_n)
        results.pay_valid |-> is_ip && pos_reg >= L4_OFFSET + UDP_HDR_LEN)
        else $error("payload flagged before end of L4 header");

endmodule

FILE: sv/l4hx_result_queue.sv
// Three-entry shift-register result queue; absorbs up to two results per byte.
// Depends on l4hx_pkg.
module l4hx_result_queue
    import l4hx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  res_pair_t results,
    output logic      full,
    output logic      head_valid,
    input  logic      head_stall,
    output result_t   head
);

    result_t      q_reg  [QDEPTH];
    result_t      q_next [QDEPTH];
    logic [1:0]   cnt_reg, cnt_next;
    logic [1:0]   base;
    logic         pop;
    logic         push_a, push_b;
    result_t      res_a;

    always_comb
    begin
        pop    = (cnt_reg != 2'd0) && !head_stall;
        base   = cnt_reg - {1'b0, pop};
        push_a = push && (results.pay_valid || results.rec_valid);
        push_b = push && results.pay_valid && results.rec_valid;
        res_a  = results.pay_valid ? results.pay : results.rec;

        for (int i = 0; i < QDEPTH - 1; i++)
            q_next[i] = pop ? q_reg[i + 1] : q_reg[i];
        q_next[QDEPTH - 1] = q_reg[QDEPTH - 1];

        for (int i = 0; i < QDEPTH; i++)
        begin
            if (push_a && base == 2'(i))
                q_next[i] = res_a;
            if (push_b && base + 2'd1 == 2'(i))
                q_next[i] = results.rec;
        end

        cnt_next = base + {1'b0, push_a} + {1'b0, push_b};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // two free entries needed before taking a byte
    assign full       = cnt_reg[1];
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[0];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cnt_reg <= 2'd1)
        else $error("push into queue without room for two results");

    a_record_follows: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && head.result_kind == KIND_PAYLOAD && !head.final_result
        |-> cnt_reg >= 2'd2 && q_reg[1].result_kind == KIND_RECORD)
        else $error("non-final payload not followed by its record");

    a_record_final: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && head.result_kind == KIND_RECORD |-> head.final_result)
        else $error("summary record without final mark");

endmodule

FILE: sv/ipv4_l4_header_extractor.sv
// A result is registered in the result queue before it is presented; when one byte
// yields a payload byte and the summary record, the record follows the payload byte.
// Throughput: one byte per cycle unless byte_stall, which rises only while two or more
// results wait in the three-entry result queue. Reset (rst_n low, async) clears all frame
// state and empties the queue.
// Top level of the IPv4/L4 header extractor; depends on l4hx_pkg, l4hx_parser
// and l4hx_result_queue.
module ipv4_l4_header_extractor
    import l4hx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // byte channel: transaction when byte_valid && !byte_stall
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic [63:0] time_now,

    // result channel: transaction when result_valid && !result_stall
    output logic        result_valid,
    input  logic        result_stall,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [31:0] source_address,
    output logic [31:0] dest_address,
    output logic [7:0]  protocol_number,
    output logic [15:0] source_port,
    output logic [15:0] dest_port,
    output logic [15:0] frame_size,
    output logic [7:0]  payload_length,
    output logic [63:0] timestamp,
    output logic        final_result
);

    logic      take;
    logic      q_full;
    res_pair_t results;
    result_t   head;

    // Stall comes only from registered queue occupancy, so there is no
    // combinational path from result_stall back to byte_stall.
    assign byte_stall = q_full;
    assign take       = byte_valid && !q_full;

    // Header decode: positions of the current frame select which field a byte
    // lands in; payload and summary results are formed in the same cycle.
    l4hx_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .time_now  (time_now),
        .results   (results)
    );

    // Result registers: payload byte goes ahead of the record of the same byte.
    l4hx_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take),
        .results    (results),
        .full       (q_full),
        .head_valid (result_valid),
        .head_stall (result_stall),
        .head       (head)
    );

    assign result_kind     = head.result_kind;
    assign payload_byte    = head.payload_byte;
    assign source_address  = head.source_address;
    assign dest_address    = head.dest_address;
    assign protocol_number = head.protocol_number;
    assign source_port     = head.source_port;
    assign dest_port       = head.dest_port;
    assign frame_size      = head.frame_size;
    assign payload_length  = head.payload_length;
    assign timestamp       = head.timestamp;
    assign final_result    = head.final_result;

endmodule

FILE: sim/tb_ipv4_l4_header_extractor.sv
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_l4_header_extractor: byte-stream frames in, payload/summary
// results out, checked against an in-bench frame parser. Depends on l4hx_pkg and the RTL top.
module tb_ipv4_l4_header_extractor;
    import l4hx_pkg::*;

    localparam int IDLE_LIMIT  = 5000;  // cycles with no transaction on either channel
    localparam int DRAIN_WAIT  = 20;    // quiet cycles after the last result
    localparam int ITEM_BUDGET = 450;   // random frames are added until this many bytes
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
    typedef enum {STALL_NONE, STALL_SOME, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [63:0] stamp;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic [63:0] time_now = 64'h0;

    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  protocol_number;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] frame_size;
    logic [7:0]  payload_length;
    logic [63:0] timestamp;
    logic        final_result;

    // Bytes waiting to be driven, and parser results waiting to show up on the output
    frame_byte_t frame_bytes[$];
    result_t     parsed_results[$];

    // Parser state, mirrors the per-frame registers of the block
    logic [15:0] fr_pos = '0;
    logic [15:0] fr_etype = '0;
    logic [7:0]  fr_proto = '0;
    logic [31:0] fr_src = '0;
    logic [31:0] fr_dst = '0;
    logic [15:0] fr_sport = '0;
    logic [15:0] fr_dport = '0;
    logic [7:0]  fr_captured = '0;

    int          total_bytes = 0;
    int          bytes_taken = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    logic        live = 1'b0;        // set once reset is released, seen by the driver
    logic        byte_moved = 1'b0;  // a byte transaction happened at the last rising edge
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    result_t     seen;
    result_t     want;

    ipv4_l4_header_extractor dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .data_byte       (data_byte),
        .frame_end       (frame_end),
        .time_now        (time_now),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_kind     (result_kind),
        .payload_byte    (payload_byte),
        .source_address  (source_address),
        .dest_address    (dest_address),
        .protocol_number (protocol_number),
        .source_port     (source_port),
        .dest_port       (dest_port),
        .frame_size      (frame_size),
        .payload_length  (payload_length),
        .timestamp       (timestamp),
        .final_result    (final_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Frame parser: consumes one accepted byte, queues the payload byte and/or
    // summary record it produces. Payload always goes ahead of the record.
    task automatic extract_byte(input logic [7:0] b, input logic last, input logic [63:0] now);
        int      at;
        int      hdr;
        int      body_start;
        int      port_at;
        int      span;
        logic    ip;
        logic    have_pay;
        result_t pay_res;
        result_t rec_res;

        at = int'(fr_pos);
        have_pay = 1'b0;
        if (at == POS_ETYPE_HI)
            fr_etype = {b, 8'h00};
        else if (at == POS_ETYPE_LO)
            fr_etype[7:0] = b;
        else if (at == POS_PROTO)
            fr_proto = b;
        else if (at >= POS_SRC_FIRST && at <= POS_SRC_LAST)
            fr_src = {fr_src[23:0], b};
        else if (at >= POS_DST_FIRST && at <= POS_DST_LAST)
            fr_dst = {fr_dst[23:0], b};

        ip = (at >= POS_IP_START) && (fr_etype == ETHERTYPE_IPV4);
        if (fr_proto == PROTO_TCP)
            hdr = int'(TCP_HDR_LEN);
        else if (fr_proto == PROTO_UDP)
            hdr = int'(UDP_HDR_LEN);
        else if (fr_proto == PROTO_ICMP)
            hdr = int'(ICMP_HDR_LEN);
        else
            hdr = 0;
        body_start = int'(L4_OFFSET) + hdr;
        // ICMP: skip type/code/checksum, echo id and sequence sit where ports would
        port_at = (fr_proto == PROTO_ICMP) ? int'(L4_OFFSET + ICMP_ID_SKIP) : int'(L4_OFFSET);

        if (ip && hdr != 0)
        begin
            if (at == port_at || at == port_at + 1)
                fr_sport = {fr_sport[7:0], b};
            else if (at == port_at + 2 || at == port_at + 3)
                fr_dport = {fr_dport[7:0], b};
            if (at >= body_start && fr_captured < CAPTURE_BYTES)
            begin
                pay_res = '0;
                pay_res.result_kind = KIND_PAYLOAD;
                pay_res.payload_byte = b;
                pay_res.final_result = 1'b1;
                fr_captured = fr_captured + 8'd1;
                have_pay = 1'b1;
            end
        end

        if (last)
        begin
            span = at + 1;
            if (span > POS_MAX)
                span = int'(POS_MAX);
            if (ip && span >= L4_OFFSET)
            begin
                pay_res.final_result = 1'b0;
                rec_res = '0;
                rec_res.result_kind = KIND_RECORD;
                rec_res.source_address = fr_src;
                rec_res.dest_address = fr_dst;
                rec_res.protocol_number = fr_proto;
                // ports only count when the whole L4 header made it in
                if (hdr != 0 && span >= body_start)
                begin
                    rec_res.source_port = fr_sport;
                    rec_res.dest_port = fr_dport;
                end
                rec_res.frame_size = span[15:0];
                rec_res.payload_length = fr_captured;
                rec_res.timestamp = now;
                rec_res.final_result = 1'b1;
                if (have_pay)
                    parsed_results.push_back(pay_res);
                parsed_results.push_back(rec_res);
                have_pay = 1'b0;
            end
            fr_pos = '0;
            fr_etype = '0;
            fr_proto = '0;
            fr_src = '0;
            fr_dst = '0;
            fr_sport = '0;
            fr_dport = '0;
            fr_captured = '0;
        end
        else if (fr_pos != POS_MAX)
            fr_pos = fr_pos + 16'd1;

        if (have_pay)
            parsed_results.push_back(pay_res);
    endtask

    task automatic check_field(input string what, input logic [63:0] exp_v, input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
            mismatches++;
        end
    endtask

    // Queue one frame; etype and protocol are forced over the fill pattern.
    task automatic add_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
                             input fill_t fill);
        frame_byte_t fb;
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO:
                begin
                    fb.data = 8'h00;
                    fb.stamp = 64'h0;
                end
                FILL_ONES:
                begin
                    fb.data = 8'hFF;
                    fb.stamp = '1;
                end
                default:
                begin
                    fb.data = 8'($urandom_range(0, 255));
                    fb.stamp = {$urandom, $urandom};
                end
            endcase
            if (i == POS_ETYPE_HI)
                fb.data = etype[15:8];
            else if (i == POS_ETYPE_LO)
                fb.data = etype[7:0];
            else if (i == POS_PROTO)
                fb.data = proto;
            fb.last = (i == len - 1);
            frame_bytes.push_back(fb);
        end
        total_bytes += len;
    endtask

    // Byte driver: bursts of random length separated by random gaps. Inputs move
    // on the falling edge; a stalled transaction is held untouched.
    always @(negedge clk)
    begin
        if (live && !(byte_valid && !byte_moved))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                byte_valid <= 1'b0;
            end
            else if (frame_bytes.size() > 0)
            begin
                data_byte <= frame_bytes[0].data;
                frame_end <= frame_bytes[0].last;
                time_now <= frame_bytes[0].stamp;
                byte_valid <= 1'b1;
                void'(frame_bytes.pop_front());
                if (burst_left <= 1)
                begin
                    // mostly short bursts, now and then a long unbroken run
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // Result-side back-pressure: a stall pattern that switches mode every so often,
    // independent of the byte side.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_mode)
            STALL_SOME:   result_stall <= ($urandom_range(0, 2) == 0);
            STALL_HEAVY:  result_stall <= ($urandom_range(0, 4) != 0);
            STALL_TOGGLE: result_stall <= stall_left[1];
            default:      result_stall <= 1'b0;
        endcase
    end

    // Monitor: at each rising edge, feed accepted bytes to the parser, compare
    // accepted results with the oldest parsed result, and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            live <= 1'b1;
            byte_moved <= byte_valid && !byte_stall;
            if (byte_valid && !byte_stall)
            begin
                extract_byte(data_byte, frame_end, time_now);
                bytes_taken++;
            end
            if (result_valid && !result_stall)
            begin
                seen = {result_kind, payload_byte, source_address, dest_address,
                        protocol_number, source_port, dest_port, frame_size,
                        payload_length, timestamp, final_result};
                if (parsed_results.size() == 0)
                begin
                    $display("%0t: result with none outstanding: kind %0d byte 0x%0h",
                             $time, seen.result_kind, seen.payload_byte);
                    mismatches++;
                end
                else
                begin
                    want = parsed_results.pop_front();
                    check_field("result_kind", want.result_kind, seen.result_kind);
                    check_field("payload_byte", want.payload_byte, seen.payload_byte);
                    check_field("source_address", want.source_address, seen.source_address);
                    check_field("dest_address", want.dest_address, seen.dest_address);
                    check_field("protocol_number", want.protocol_number,
                                seen.protocol_number);
                    check_field("source_port", want.source_port, seen.source_port);
                    check_field("dest_port", want.dest_port, seen.dest_port);
                    check_field("frame_size", want.frame_size, seen.frame_size);
                    check_field("payload_length", want.payload_length, seen.payload_length);
                    check_field("timestamp", want.timestamp, seen.timestamp);
                    check_field("final_result", want.final_result, seen.final_result);
                end
            end
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int          len;
        int          hdr;
        int          pick;
        logic [15:0] etype;
        logic [7:0]  proto;

        // Directed frames: boundaries of the IPv4/L4 layout and the odd cases
        add_frame(1, 16'h0000, 8'h00, FILL_RANDOM);              // single-byte frame
        add_frame(33, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);   // one byte short of addresses
        add_frame(34, ETHERTYPE_IPV4, PROTO_TCP, FILL_ZERO);     // addresses only, no TCP header
        add_frame(40, ETHERTYPE_IPV6, PROTO_TCP, FILL_RANDOM);
        add_frame(55, ETHERTYPE_IPV4, PROTO_TCP, FILL_RANDOM);   // final byte is also payload
        add_frame(44, ETHERTYPE_IPV4, PROTO_ICMP, FILL_RANDOM);  // echo id/sequence
        add_frame(40, ETHERTYPE_IPV4, PROTO_ICMP, FILL_RANDOM);  // echo header cut after the id
        add_frame(171, ETHERTYPE_IPV4, PROTO_UDP, FILL_ONES);    // all-ones, past capture limit

        // Random frames: mostly well-formed IPv4 with random content, plus
        // foreign ethertypes, runts and plain noise
        while (total_bytes < ITEM_BUDGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: proto = PROTO_TCP;
                3, 4, 5: proto = PROTO_UDP;
                6, 7:    proto = PROTO_ICMP;
                default: proto = 8'($urandom_range(0, 255));
            endcase
            if (proto == PROTO_TCP)
                hdr = int'(TCP_HDR_LEN);
            else if (proto == PROTO_UDP)
                hdr = int'(UDP_HDR_LEN);
            else if (proto == PROTO_ICMP)
                hdr = int'(ICMP_HDR_LEN);
            else
                hdr = 0;
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                etype = ETHERTYPE_IPV4;
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(L4_OFFSET, L4_OFFSET + hdr);
                    8:       len = L4_OFFSET + hdr + $urandom_range(120, 140);
                    9:       len = L4_OFFSET + hdr + $urandom_range(25, 100);
                    default: len = L4_OFFSET + hdr + $urandom_range(0, 24);
                endcase
            end
            else if (pick < 85)
            begin
                // near misses on the ethertype as well as arbitrary ones
                etype = ($urandom_range(0, 1) == 0)
                        ? ETHERTYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15))
                        : 16'($urandom_range(0, 65535));
                len = $urandom_range(14, 80);
            end
            else if (pick < 95)
            begin
                etype = ETHERTYPE_IPV4;
                len = $urandom_range(1, L4_OFFSET - 1);
            end
            else
            begin
                etype = 16'($urandom_range(0, 65535));
                len = $urandom_range(1, 120);
            end
            add_frame(len, etype, proto, FILL_RANDOM);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (bytes_taken < total_bytes)
            @(negedge clk);
        while (parsed_results.size() != 0)
            @(negedge clk);
        // catch any stray result the block still has in flight
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: ipv4_l4_header_extractor.f
sv/l4hx_pkg.sv
sv/l4hx_parser.sv
sv/l4hx_result_queue.sv
sv/ipv4_l4_header_extractor.sv
sim/tb_ipv4_l4_header_extractor.sv
